// ----- hw/rtl/sdt_pkg.sv -----
// Shared constants, types and helper functions for the sleep deadline table.
// Used by the top level and the port checker.
package sdt_pkg;

    localparam int MAX_SLOTS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int TASK_W     = 8;
    localparam int LEN_W      = 16;
    localparam int REM_W      = 16;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int ENTRY_W    = TASK_W + 2 * COUNT_BITS;
    localparam int WIDE_W     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [MAX_SLOTS-1:0]  slot_mask_t;
    typedef logic [TASK_W-1:0]     task_t;

    typedef enum logic [1:0] {
        REQ_SLEEP  = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_REMOVE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_IMMEDIATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_WOKEN     = 3'd3,
        ST_NOTHING   = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESULT,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    // Clamp a requested length to the counter range.
    function automatic count_t sat_len(input logic [LEN_W-1:0] len);
        logic [WIDE_W-1:0] v;
        logic [WIDE_W-1:0] m;
        begin
            v = WIDE_W'(len);
            m = WIDE_W'({COUNT_BITS{1'b1}});
            sat_len = count_t'((v > m) ? m : v);
        end
    endfunction

    // Clamp a remaining time to the result field.
    function automatic logic [REM_W-1:0] sat_rem(input count_t rem);
        logic [WIDE_W-1:0] v;
        logic [WIDE_W-1:0] m;
        begin
            v = WIDE_W'(rem);
            m = WIDE_W'({REM_W{1'b1}});
            sat_rem = REM_W'((v > m) ? m : v);
        end
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic slot_idx_t lowest_set(input slot_mask_t m);
        slot_idx_t idx;
        begin
            idx = '0;
            for (int i = MAX_SLOTS - 1; i >= 0; i--)
            begin
                if (m[i])
                    idx = SLOT_W'(i);
            end
            lowest_set = idx;
        end
    endfunction

endpackage

// ----- hw/rtl/sleep_deadline_table_top.sv -----
// Sleep deadline table: slot contents in one RAM, valid bits and counter in flops.
// Flow: a request is taken in S_IDLE, S_SCAN reads every slot, S_DECIDE updates the table,
// S_RESULT registers the result; a waking tick instead alternates S_EMIT_RD and S_EMIT_OUT.
// Requests are handled one at a time, each paced by the single RAM read port that scans
// one slot per cycle and re-reads each woken slot.
// Reset: valid bits, tick counter and control clear at once; slot contents are not cleared.
// Depends on sdt_pkg and sdt_ram.
module sleep_deadline_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] task_id, [23:8] sleep_length
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] woken_id, [23:8] next_remaining
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    sdt_pkg::state_t     state_reg, state_next;
    logic [sdt_pkg::SCNT_W-1:0] cnt_reg, cnt_next;
    sdt_pkg::req_t       req_reg, req_next;
    sdt_pkg::task_t      id_reg, id_next;
    sdt_pkg::count_t     len_reg, len_next;
    logic                zero_reg, zero_next;
    sdt_pkg::count_t     now_reg, now_next;
    sdt_pkg::slot_mask_t valid_reg, valid_next;
    sdt_pkg::slot_mask_t due_reg, due_next;
    logic                match_reg, match_next;
    sdt_pkg::slot_idx_t  match_idx_reg, match_idx_next;
    logic                any_reg, any_next;
    sdt_pkg::count_t     min_reg, min_next;
    sdt_pkg::status_t    res_status_reg, res_status_next;
    sdt_pkg::task_t      res_id_reg, res_id_next;
    sdt_pkg::slot_idx_t  emit_idx_reg, emit_idx_next;

    logic                out_valid_reg, out_valid_next;
    sdt_pkg::status_t    out_status_reg, out_status_next;
    sdt_pkg::task_t      out_id_reg, out_id_next;
    logic [sdt_pkg::REM_W-1:0] out_rem_reg, out_rem_next;
    logic                out_last_reg, out_last_next;

    logic                        ram_we;
    sdt_pkg::slot_idx_t          ram_waddr;
    logic [sdt_pkg::ENTRY_W-1:0] ram_wdata;
    sdt_pkg::slot_idx_t          ram_raddr;
    logic [sdt_pkg::ENTRY_W-1:0] ram_rdata;

    sdt_pkg::task_t      ent_task;
    sdt_pkg::count_t     ent_start;
    sdt_pkg::count_t     ent_len;
    sdt_pkg::count_t     ent_el;
    sdt_pkg::count_t     ent_rem;
    logic                ent_due;
    logic                ent_match;
    logic                ent_kept;
    sdt_pkg::slot_idx_t  proc_idx;
    logic                out_free;
    logic                in_take;
    logic                has_free;
    sdt_pkg::slot_idx_t  free_idx;
    logic [sdt_pkg::REM_W-1:0] next_rem;

    sdt_ram #(
        .WIDTH (sdt_pkg::ENTRY_W),
        .DEPTH (sdt_pkg::MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == sdt_pkg::S_IDLE);
    assign in_take  = s_tvalid & s_tready;
    assign out_free = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rem_reg, out_id_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Slot entry layout: task, start, length from the lowest bit up
    assign ent_task  = ram_rdata[sdt_pkg::TASK_W-1:0];
    assign ent_start = ram_rdata[sdt_pkg::TASK_W +: sdt_pkg::COUNT_BITS];
    assign ent_len   = ram_rdata[sdt_pkg::TASK_W + sdt_pkg::COUNT_BITS +: sdt_pkg::COUNT_BITS];
    assign ent_el    = now_reg - ent_start;
    assign ent_due   = (ent_el >= ent_len);
    assign ent_rem   = ent_due ? '0 : (ent_len - ent_el);
    assign ent_match = (ent_task == id_reg);
    assign proc_idx  = sdt_pkg::SLOT_W'(cnt_reg - sdt_pkg::SCNT_W'(1));

    assign has_free = |(~valid_reg);
    assign free_idx = sdt_pkg::lowest_set(~valid_reg);
    assign next_rem = any_reg ? sdt_pkg::sat_rem(min_reg) : '0;

    always_comb
    begin
        case (req_reg)
            sdt_pkg::REQ_TICK:   ent_kept = ~ent_due;
            sdt_pkg::REQ_REMOVE: ent_kept = ~ent_match;
            default:             ent_kept = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        zero_next       = zero_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        due_next        = due_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        any_next        = any_reg;
        min_next        = min_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_idx;
        ram_wdata       = {len_reg, now_reg, id_reg};
        ram_raddr       = emit_idx_reg;

        case (state_reg)
            sdt_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    case (s_tuser)
                        sdt_pkg::REQ_SLEEP, sdt_pkg::REQ_TICK, sdt_pkg::REQ_REMOVE:
                        begin
                            req_next   = sdt_pkg::req_t'(s_tuser);
                            id_next    = s_tdata[7:0];
                            len_next   = sdt_pkg::sat_len(s_tdata[23:8]);
                            zero_next  = (s_tdata[23:8] == '0);
                            cnt_next   = '0;
                            due_next   = '0;
                            match_next = 1'b0;
                            any_next   = 1'b0;
                            state_next = sdt_pkg::S_SCAN;
                            // counter runs only while some task sleeps
                            if ((s_tuser == sdt_pkg::REQ_TICK) && (|valid_reg))
                                now_next = now_reg + sdt_pkg::count_t'(1);
                        end
                        default:
                        begin
                            // unknown request: drop silently
                        end
                    endcase
                end
            end

            sdt_pkg::S_SCAN:
            begin
                ram_raddr = (cnt_reg < sdt_pkg::SCNT_W'(sdt_pkg::MAX_SLOTS))
                          ? sdt_pkg::SLOT_W'(cnt_reg) : '0;
                cnt_next  = cnt_reg + sdt_pkg::SCNT_W'(1);
                // read data is registered: it belongs to the address of the previous cycle
                if ((cnt_reg != '0) && valid_reg[proc_idx])
                begin
                    if (ent_match)
                    begin
                        match_next     = 1'b1;
                        match_idx_next = proc_idx;
                    end
                    if (ent_due)
                        due_next[proc_idx] = 1'b1;
                    if (ent_kept && (!any_reg || (ent_rem < min_reg)))
                    begin
                        min_next = ent_rem;
                        any_next = 1'b1;
                    end
                end
                if (cnt_reg == sdt_pkg::SCNT_W'(sdt_pkg::MAX_SLOTS))
                    state_next = sdt_pkg::S_DECIDE;
            end

            sdt_pkg::S_DECIDE:
            begin
                res_id_next = id_reg;
                state_next  = sdt_pkg::S_RESULT;
                case (req_reg)
                    sdt_pkg::REQ_SLEEP:
                    begin
                        if (zero_reg)
                            res_status_next = sdt_pkg::ST_IMMEDIATE;
                        else if (match_reg || !has_free)
                            res_status_next = sdt_pkg::ST_FULL;
                        else
                        begin
                            ram_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            res_status_next      = sdt_pkg::ST_ACCEPTED;
                            if (!any_reg || (len_reg < min_reg))
                                min_next = len_reg;
                            any_next = 1'b1;
                        end
                    end
                    sdt_pkg::REQ_REMOVE:
                    begin
                        if (match_reg)
                        begin
                            valid_next[match_idx_reg] = 1'b0;
                            res_status_next           = sdt_pkg::ST_REMOVED;
                        end
                        else
                            res_status_next = sdt_pkg::ST_NOT_FOUND;
                    end
                    default:
                    begin
                        if (|due_reg)
                        begin
                            valid_next = valid_reg & ~due_reg;
                            state_next = sdt_pkg::S_EMIT_RD;
                        end
                        else
                        begin
                            res_status_next = sdt_pkg::ST_NOTHING;
                            res_id_next     = '0;
                        end
                    end
                endcase
            end

            sdt_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_rem_next    = next_rem;
                    out_last_next   = 1'b1;
                    state_next      = sdt_pkg::S_IDLE;
                end
            end

            sdt_pkg::S_EMIT_RD:
            begin
                // fetch the next woken slot in slot order
                ram_raddr     = sdt_pkg::lowest_set(due_reg);
                emit_idx_next = sdt_pkg::lowest_set(due_reg);
                state_next    = sdt_pkg::S_EMIT_OUT;
            end

            sdt_pkg::S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    due_next[emit_idx_reg] = 1'b0;
                    out_valid_next  = 1'b1;
                    out_status_next = sdt_pkg::ST_WOKEN;
                    out_id_next     = ent_task;
                    out_rem_next    = next_rem;
                    out_last_next   = (due_next == '0);
                    state_next      = (due_next == '0) ? sdt_pkg::S_IDLE : sdt_pkg::S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = sdt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdt_pkg::S_IDLE;
            cnt_reg       <= '0;
            req_reg       <= sdt_pkg::REQ_SLEEP;
            now_reg       <= '0;
            valid_reg     <= '0;
            due_reg       <= '0;
            match_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            due_reg       <= due_next;
            match_reg     <= match_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        len_reg        <= len_next;
        zero_reg       <= zero_next;
        match_idx_reg  <= match_idx_next;
        min_reg        <= min_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        emit_idx_reg   <= emit_idx_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- hw/rtl/sdt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sdt_checker.sv -----
// Port-level checks for the sleep deadline table, bound to the top level.
// Depends on sdt_pkg for status and request codes.
module sdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // only wake results come in runs; every other result closes its request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != sdt_pkg::ST_WOKEN) |-> m_tlast)
        else $error("non-wake result without last");

    // a tick that wakes nobody reports task zero
    a_nothing_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sdt_pkg::ST_NOTHING) |-> (m_tdata[7:0] == 8'd0))
        else $error("nothing-woke result with nonzero id");

    // a known request is processed before the next one is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser == sdt_pkg::REQ_SLEEP)
            || (s_tuser == sdt_pkg::REQ_TICK) || (s_tuser == sdt_pkg::REQ_REMOVE))
        |=> !s_tready)
        else $error("request taken while busy");

    // status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 3'd7))
        else $error("undefined status code");

endmodule

bind sleep_deadline_table_top sdt_checker u_sdt_checker (.*);
